### src/lsie_pkg.sv
// Shared types, opcodes and constants of the load/store instruction executor.
package lsie_pkg;

	// Default depth of the data memory in words
	localparam int unsigned DATA_WORDS_DEF = 1024;

	// Decode queue depth; a power of two so the pointers wrap on their own
	localparam int unsigned QUEUE_DEPTH = 2;

	// Opcode field values
	localparam logic [5:0] OPC_ALU_LAST = 6'd11;
	localparam logic [5:0] OPC_LDW      = 6'd12;
	localparam logic [5:0] OPC_STW      = 6'd13;
	localparam logic [5:0] OPC_BZ       = 6'd14;
	localparam logic [5:0] OPC_BEQ      = 6'd15;
	localparam logic [5:0] OPC_JR       = 6'd16;
	localparam logic [5:0] OPC_HALT     = 6'd17;

	// Result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_HALT  = 2'd1;
	localparam logic [1:0] STATUS_UNDEF = 2'd2;

	typedef enum logic [3:0] {
		K_ALU_R,
		K_ALU_I,
		K_LDW,
		K_STW,
		K_BZ,
		K_BEQ,
		K_JR,
		K_HALT,
		K_UNDEF
	} lsie_kind_t;

	// Order follows the opcode pairs: opcode >> 1
	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_OR,
		ALU_AND,
		ALU_XOR
	} lsie_alu_t;

	typedef struct packed {
		lsie_kind_t  kind;
		lsie_alu_t   alu;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [31:0] imm;
	} lsie_op_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [1:0]  status;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [9:0]  mem_address;
		logic        branch_taken;
	} lsie_res_t;

endpackage

### src/lsie_front.sv
// Front end: instruction acceptance and decode into a classified operation.
module lsie_front import lsie_pkg::*; (
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instruction_word,
	input  logic        q_full,
	input  logic        clr_done,
	output logic        push,
	output lsie_op_t    push_op
);

	logic [5:0] opc;

	assign instr_ready = !q_full && clr_done;
	assign push        = instr_valid && instr_ready;
	assign opc         = instruction_word[31:26];

	always_comb begin
		push_op.rs   = instruction_word[25:21];
		push_op.rt   = instruction_word[20:16];
		push_op.rd   = instruction_word[15:11];
		push_op.imm  = {{16{instruction_word[15]}}, instruction_word[15:0]};
		push_op.alu  = ALU_ADD;
		push_op.kind = K_UNDEF;
		if (opc <= OPC_ALU_LAST) begin
			// odd opcodes take the immediate
			push_op.kind = opc[0] ? K_ALU_I : K_ALU_R;
			push_op.alu  = lsie_alu_t'(opc[3:1]);
		end else begin
			case (opc)
				OPC_LDW:  push_op.kind = K_LDW;
				OPC_STW:  push_op.kind = K_STW;
				OPC_BZ:   push_op.kind = K_BZ;
				OPC_BEQ:  push_op.kind = K_BEQ;
				OPC_JR:   push_op.kind = K_JR;
				OPC_HALT: push_op.kind = K_HALT;
				default:  push_op.kind = K_UNDEF;
			endcase
		end
	end

endmodule

### src/lsie_queue.sv
// Short queue of decoded operations between the front and back ends.
module lsie_queue import lsie_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lsie_op_t push_op,
	input  logic     pop,
	output logic     head_valid,
	output lsie_op_t head_op,
	output logic     full
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	lsie_op_t        ent_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign head_valid = cnt_q != '0;
	assign full       = cnt_q == CW'(QUEUE_DEPTH);
	assign head_op    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_op;
	end

endmodule

### src/lsie_amod.sv
// Effective address reduction modulo the data memory depth.
module lsie_amod import lsie_pkg::*; #(
	parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [31:0]                   x,
	output logic                          out_valid,
	output logic [$clog2(DATA_WORDS)-1:0] addr
);

	localparam int unsigned AW      = $clog2(DATA_WORDS);
	localparam bit          IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

	if (IS_POW2) begin : g_mask
		logic          valid_s1;
		logic [AW-1:0] addr_s1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s1 <= 1'b0;
			else
				valid_s1 <= in_valid;
		end

		// hold the last address until the next request
		always_ff @(posedge clk) begin
			if (in_valid)
				addr_s1 <= x[AW-1:0];
		end

		assign out_valid = valid_s1;
		assign addr      = addr_s1;
	end else begin : g_recip
		// quotient estimate x*floor(2^32/N) >> 32 is low by at most one
		localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(DATA_WORDS);
		localparam logic [31:0] RECIP   = RECIP64[31:0];
		localparam int unsigned RW      = $clog2(2 * DATA_WORDS);
		localparam logic [RW-1:0] NW    = RW'(DATA_WORDS);

		logic          valid_s1;
		logic          valid_s2;
		logic [63:0]   prod_s1;
		logic [31:0]   x_s1;
		logic [31:0]   rem_c;
		logic [RW-1:0] rem_s2;
		logic [RW-1:0] fix_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s1 <= 1'b0;
				valid_s2 <= 1'b0;
			end else begin
				valid_s1 <= in_valid;
				valid_s2 <= valid_s1;
			end
		end

		assign rem_c = x_s1 - 32'(prod_s1[63:32] * 32'(DATA_WORDS));

		always_ff @(posedge clk) begin
			if (in_valid) begin
				prod_s1 <= 64'(x) * 64'(RECIP);
				x_s1    <= x;
			end
			if (valid_s1)
				rem_s2 <= rem_c[RW-1:0];
		end

		// remainder is below twice the depth: one conditional subtract
		assign fix_c     = (rem_s2 >= NW) ? (rem_s2 - NW) : rem_s2;
		assign out_valid = valid_s2;
		assign addr      = fix_c[AW-1:0];
	end

endmodule

### src/lsie_back.sv
// Back end: register file, data memory, program counter and result register.
module lsie_back import lsie_pkg::*; #(
	parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  lsie_op_t  head_op,
	output logic      pop,
	output logic      clr_done,
	output logic      res_valid,
	input  logic      res_ready,
	output lsie_res_t res
);

	localparam int unsigned AW = $clog2(DATA_WORDS);

	typedef enum logic [4:0] {
		BK_IDLE  = 5'b00001,
		BK_EXEC  = 5'b00010,
		BK_AGEN  = 5'b00100,
		BK_LOAD  = 5'b01000,
		BK_STORE = 5'b10000
	} bk_state_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_RAM,
		SRC_FWD
	} src_t;

	bk_state_t   state_q;
	bk_state_t   state_d;
	lsie_op_t    op_s1;
	logic [31:0] pc_q;

	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic [31:0] fwd_q;
	src_t        a_src_q;
	src_t        b_src_q;
	src_t        a_src_d;
	src_t        b_src_d;

	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] dmem_rd_q;
	logic [AW:0] clr_cnt_q;

	lsie_res_t   res_q;
	lsie_res_t   res_c;
	logic        res_valid_q;
	logic        out_free;
	logic        done;
	logic        is_mem;

	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] alu_b;
	logic [31:0] alu_y;
	logic [31:0] br_off;

	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;

	logic          amod_start;
	logic          amod_done;
	logic [AW-1:0] amod_addr;
	logic [31:0]   mem_idx;

	assign out_free  = !res_valid_q || res_ready;
	assign clr_done  = clr_cnt_q == (AW + 1)'(DATA_WORDS);
	assign is_mem    = (op_s1.kind == K_LDW) || (op_s1.kind == K_STW);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// operand select: cleared entry, stored word or the write of the same cycle
	always_comb begin
		case (a_src_q)
			SRC_RAM: a = rd_a_q;
			SRC_FWD: a = fwd_q;
			default: a = '0;
		endcase
		case (b_src_q)
			SRC_RAM: b = rd_b_q;
			SRC_FWD: b = fwd_q;
			default: b = '0;
		endcase
	end

	assign alu_b = (op_s1.kind == K_ALU_I) ? op_s1.imm : b;

	always_comb begin
		case (op_s1.alu)
			ALU_ADD: alu_y = a + alu_b;
			ALU_SUB: alu_y = a - alu_b;
			ALU_MUL: alu_y = 32'(a * alu_b);
			ALU_OR:  alu_y = a | alu_b;
			ALU_AND: alu_y = a & alu_b;
			default: alu_y = a ^ alu_b;
		endcase
	end

	// address reduction for loads and stores
	assign amod_start = (state_q == BK_EXEC) && is_mem;

	lsie_amod #(
		.DATA_WORDS(DATA_WORDS)
	) u_amod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (amod_start),
		.x        (a + op_s1.imm),
		.out_valid(amod_done),
		.addr     (amod_addr)
	);

	assign mem_idx = 32'(amod_addr);

	always_comb begin
		res_c         = '0;
		res_c.status  = STATUS_OK;
		br_off        = '0;
		done          = 1'b0;
		case (state_q)
			BK_EXEC: begin
				done = out_free && !is_mem;
				case (op_s1.kind)
					K_ALU_R: begin
						res_c.reg_write = 1'b1;
						res_c.reg_index = op_s1.rd;
						res_c.reg_value = alu_y;
					end
					K_ALU_I: begin
						res_c.reg_write = 1'b1;
						res_c.reg_index = op_s1.rt;
						res_c.reg_value = alu_y;
					end
					K_BZ: begin
						if (b == '0) begin
							res_c.branch_taken = 1'b1;
							br_off             = {op_s1.imm[29:0], 2'b00};
						end
					end
					K_BEQ: begin
						if (b == a) begin
							res_c.branch_taken = 1'b1;
							br_off             = {op_s1.imm[29:0], 2'b00};
						end
					end
					K_JR: begin
						res_c.branch_taken = 1'b1;
						br_off             = {b[29:0], 2'b00};
					end
					K_LDW, K_STW: begin
						res_c.status = STATUS_OK;
					end
					K_HALT:  res_c.status = STATUS_HALT;
					default: res_c.status = STATUS_UNDEF;
				endcase
			end
			BK_LOAD: begin
				done              = out_free;
				res_c.reg_write   = 1'b1;
				res_c.reg_index   = op_s1.rt;
				res_c.reg_value   = dmem_rd_q;
				res_c.mem_address = mem_idx[9:0];
			end
			BK_STORE: begin
				done              = out_free;
				res_c.mem_write   = 1'b1;
				res_c.mem_address = mem_idx[9:0];
			end
			default: done = 1'b0;
		endcase
		// halt and undefined opcodes leave the counter alone
		res_c.next_pc = (res_c.status == STATUS_OK) ? (pc_q + br_off + 32'd4) : pc_q;
	end

	// take the next operation as soon as the current one retires
	assign pop = head_valid && clr_done && ((state_q == BK_IDLE) || done);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (pop) state_d = BK_EXEC;
			BK_EXEC:  if (is_mem) state_d = BK_AGEN;
			BK_AGEN: begin
				if (amod_done)
					state_d = (op_s1.kind == K_LDW) ? BK_LOAD : BK_STORE;
			end
			BK_LOAD, BK_STORE: state_d = state_q;
			default: state_d = BK_IDLE;
		endcase
		if (done)
			state_d = pop ? BK_EXEC : BK_IDLE;
	end

	assign rf_we    = done && res_c.reg_write;
	assign rf_waddr = res_c.reg_index;
	assign rf_wdata = res_c.reg_value;

	always_comb begin
		if (rf_we && (rf_waddr == head_op.rs))
			a_src_d = SRC_FWD;
		else if (rf_vld_q[head_op.rs])
			a_src_d = SRC_RAM;
		else
			a_src_d = SRC_ZERO;
		if (rf_we && (rf_waddr == head_op.rt))
			b_src_d = SRC_FWD;
		else if (rf_vld_q[head_op.rt])
			b_src_d = SRC_RAM;
		else
			b_src_d = SRC_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pc_q        <= '0;
			rf_vld_q    <= '0;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
			a_src_q     <= SRC_ZERO;
			b_src_q     <= SRC_ZERO;
		end else begin
			state_q <= state_d;
			if (!clr_done)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (done)
				pc_q <= res_c.next_pc;
			if (rf_we)
				rf_vld_q[rf_waddr] <= 1'b1;
			if (pop) begin
				a_src_q <= a_src_d;
				b_src_q <= b_src_d;
			end
			if (done)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// register file: one write, two registered reads
	always_ff @(posedge clk) begin
		if (rf_we)
			rf_mem[rf_waddr] <= rf_wdata;
		if (pop) begin
			rd_a_q <= rf_mem[head_op.rs];
			rd_b_q <= rf_mem[head_op.rt];
			fwd_q  <= rf_wdata;
			op_s1  <= head_op;
		end
	end

	// data memory: clearing sweep, then stores; registered load read
	always_ff @(posedge clk) begin
		if (!clr_done)
			dmem[clr_cnt_q[AW-1:0]] <= '0;
		else if (done && (state_q == BK_STORE))
			dmem[amod_addr] <= b;
		if ((state_q == BK_AGEN) && amod_done && (op_s1.kind == K_LDW))
			dmem_rd_q <= dmem[amod_addr];
	end

	always_ff @(posedge clk) begin
		if (done)
			res_q <= res_c;
	end

endmodule

### src/load_store_isa_executor.sv
// Top level of the load/store instruction executor.
//
// Executes one 32-bit instruction per input transaction against a 32-entry
// register file, a DATA_WORDS-word data memory and a program counter, and
// returns one result transaction per instruction, in order. After reset the
// data memory is cleared by a sweep over all its words, during which
// instr_ready stays low. A decoded instruction waits in a two-entry queue;
// the back end reads its operands from the register file in the cycle it
// leaves the queue, with the write of that same cycle forwarded, so an
// instruction sees everything written by those ahead of it. Register
// arithmetic, branches, jumps, halt and undefined opcodes retire at one per
// cycle while results are taken, each going from the execute state into the
// result register. LDW and STW add the address generation and load or store
// states; address reduction masks for a power-of-two DATA_WORDS, else does
// a reciprocal multiply then one correcting subtract. The result register
// lets the front end keep taking instructions while a result waits.
module load_store_isa_executor import lsie_pkg::*; #(
	parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               instr_valid,
	output logic               instr_ready,
	input  logic [31:0]        instruction_word,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [31:0]        next_pc,
	output logic [1:0]         status,
	output logic               reg_write,
	output logic [4:0]         reg_index,
	output logic signed [31:0] reg_value,
	output logic               mem_write,
	output logic [9:0]         mem_address,
	output logic               branch_taken
);

	logic      push;
	lsie_op_t  push_op;
	logic      q_full;
	logic      pop;
	logic      head_valid;
	lsie_op_t  head_op;
	logic      clr_done;
	lsie_res_t res;

	// accept and decode
	lsie_front u_front (
		.instr_valid     (instr_valid),
		.instr_ready     (instr_ready),
		.instruction_word(instruction_word),
		.q_full          (q_full),
		.clr_done        (clr_done),
		.push            (push),
		.push_op         (push_op)
	);

	// decouple decode from execution
	lsie_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.head_valid(head_valid),
		.head_op   (head_op),
		.full      (q_full)
	);

	// execute, update state and hold the result
	lsie_back #(
		.DATA_WORDS(DATA_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_op   (head_op),
		.pop       (pop),
		.clr_done  (clr_done),
		.res_valid (result_valid),
		.res_ready (result_ready),
		.res       (res)
	);

	// unpack the result register onto the ports
	assign next_pc      = res.next_pc;
	assign status       = res.status;
	assign reg_write    = res.reg_write;
	assign reg_index    = res.reg_index;
	assign reg_value    = $signed(res.reg_value);
	assign mem_write    = res.mem_write;
	assign mem_address  = res.mem_address;
	assign branch_taken = res.branch_taken;

endmodule

### src/lsie_checker.sv
// Port-level checks on the executor's result transactions, bound to the top level.
module lsie_checker import lsie_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input logic [31:0]        next_pc,
	input logic [1:0]         status,
	input logic               reg_write,
	input logic [4:0]         reg_index,
	input logic signed [31:0] reg_value,
	input logic               mem_write,
	input logic [9:0]         mem_address,
	input logic               branch_taken
);

	logic [31:0] last_pc_q;

	// counter value after the last delivered transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_pc_q <= '0;
		else if (result_valid && result_ready)
			last_pc_q <= next_pc;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(next_pc) &&
		$stable(reg_value) && $stable(mem_address) && $stable(status))
		else $error("result changed while stalled");

	a_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != STATUS_OK) |-> (next_pc == last_pc_q) &&
		!reg_write && !mem_write && !branch_taken)
		else $error("halt or undefined opcode changed state");

	a_one_effect: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(reg_write && mem_write) &&
		!(branch_taken && (reg_write || mem_write)))
		else $error("more than one kind of side effect");

	a_quiet_reg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !reg_write |-> (reg_index == 5'd0) && (reg_value == 32'sd0))
		else $error("register fields set without a register write");

endmodule

bind load_store_isa_executor lsie_checker u_lsie_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.next_pc     (next_pc),
	.status      (status),
	.reg_write   (reg_write),
	.reg_index   (reg_index),
	.reg_value   (reg_value),
	.mem_write   (mem_write),
	.mem_address (mem_address),
	.branch_taken(branch_taken)
);
